### sv/sdts_pkg.sv
// Package: sizes, codes and shared types of the sorted day table search block.
`default_nettype none
package sdts_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int DAY_BITS    = 24;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;      // holds TABLE_DEPTH itself
	localparam int IDX_W       = COUNT_W + 1;     // signed probe bounds, hi may reach -1

	// Transaction field widths
	localparam int CMD_W     = 1;
	localparam int SLOT_W    = 12;
	localparam int DAY_W     = 24;
	localparam int OUTCOME_W = 2;
	localparam int CFG_W     = 13;

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

	// Outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_LOAD  = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_INDEX = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_UNDER = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_OVER  = 2'd3;

	typedef logic signed [IDX_W-1:0] idx_t;
	typedef logic [DAY_BITS-1:0]     day_t;
	typedef logic [ADDR_W-1:0]       addr_t;

endpackage
`default_nettype wire

### sv/sdts_if.sv
// Interfaces: request and response channels of the sorted day table search block.
`default_nettype none

interface sdts_req_if;
	logic                                valid;
	logic                                ready;
	logic [sdts_pkg::CMD_W-1:0]          command;
	logic [sdts_pkg::SLOT_W-1:0]         entry_slot;
	logic [sdts_pkg::DAY_W-1:0]          entry_day;
	logic [sdts_pkg::DAY_W-1:0]          query_day;

	modport source (output valid, command, entry_slot, entry_day, query_day, input ready);
	modport sink   (input valid, command, entry_slot, entry_day, query_day, output ready);
endinterface

interface sdts_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sdts_pkg::OUTCOME_W-1:0]      outcome;
	logic [sdts_pkg::SLOT_W-1:0]         found_slot;

	modport source (output valid, outcome, found_slot, input ready);
	modport sink   (input valid, outcome, found_slot, output ready);
endinterface

`default_nettype wire

### sv/sorted_date_table_search.sv
// Top level: day table in a synchronous RAM with a sequential binary search over it.
//
// The block keeps a table of up to 4096 ascending 24-bit day numbers in one
// synchronous RAM with one write port and one registered read port. A load
// transaction writes one entry and answers "load done". A search transaction
// first checks the query against entry 0 and entry count-1 (below range /
// above range), then runs a binary search with one RAM read per probe: the
// next probe address is formed in the same cycle as the compare. One
// transaction is in flight at a time: req.ready is high only while the engine
// is idle, and a finished result sits in an output register so the next
// request can be taken while the response waits. entries_in_use
// (cfg_we/cfg_wdata) gives the live table size; 0 acts as 1 and values above
// 4096 act as 4096. It may be written only while the block is idle. Entries
// that are searched must have been loaded first; the RAM has no reset and no
// clearing pass.
`default_nettype none
module sorted_date_table_search (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	sdts_req_if.sink                          req,
	sdts_rsp_if.source                        rsp,
	input  wire logic                         cfg_we,
	input  wire logic [sdts_pkg::CFG_W-1:0]   cfg_wdata
);

	// Engine states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LO   = 3'd1;   // entry 0 data arriving
	localparam logic [2:0] ST_HI   = 3'd2;   // entry count-1 data arriving
	localparam logic [2:0] ST_CMP  = 3'd3;   // probe data arriving
	localparam logic [2:0] ST_OUT  = 3'd4;   // result waiting for output register

	logic [2:0]                        state_q, state_d;
	logic [sdts_pkg::CFG_W-1:0]        entries_in_use_q;

	// Search registers
	sdts_pkg::day_t                    query_q;
	sdts_pkg::idx_t                    lo_q, lo_d;
	sdts_pkg::idx_t                    hi_q, hi_d;
	sdts_pkg::idx_t                    mid_q, mid_d;

	// Pending result
	logic [sdts_pkg::OUTCOME_W-1:0]    res_outcome_q, res_outcome_d;
	logic [sdts_pkg::SLOT_W-1:0]       res_slot_q, res_slot_d;

	// Output register
	logic                              out_valid_q;
	logic [sdts_pkg::OUTCOME_W-1:0]    out_outcome_q;
	logic [sdts_pkg::SLOT_W-1:0]       out_slot_q;

	// RAM
	sdts_pkg::day_t                    day_mem [sdts_pkg::TABLE_DEPTH];
	sdts_pkg::day_t                    rd_data_q;
	sdts_pkg::addr_t                   rd_addr;
	logic                              mem_we;

	logic                              req_fire;
	logic                              out_load;
	sdts_pkg::idx_t                    eff_count;
	sdts_pkg::idx_t                    step_lo, step_hi, step_mid;
	sdts_pkg::idx_t                    sum_hi, sum_lo;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign mem_we    = req_fire && (req.command == sdts_pkg::CMD_LOAD) &&
	                   (32'(req.entry_slot) < 32'(sdts_pkg::TABLE_DEPTH));

	// Clamp the configured count into 1..TABLE_DEPTH
	always_comb begin
		if (entries_in_use_q == '0) begin
			eff_count = sdts_pkg::idx_t'(1);
		end else if (32'(entries_in_use_q) > 32'(sdts_pkg::TABLE_DEPTH)) begin
			eff_count = sdts_pkg::idx_t'(sdts_pkg::TABLE_DEPTH);
		end else begin
			eff_count = sdts_pkg::idx_t'(entries_in_use_q);
		end
	end

	// One probe step: both sums stay non-negative on the branch that uses them
	assign sum_hi = hi_q + mid_q;
	assign sum_lo = lo_q + mid_q;

	always_comb begin
		if (query_q > rd_data_q) begin
			step_lo  = mid_q + sdts_pkg::idx_t'(1);
			step_hi  = hi_q;
			step_mid = sum_hi >>> 1;
		end else begin
			step_lo  = lo_q;
			step_hi  = mid_q - sdts_pkg::idx_t'(1);
			step_mid = sum_lo >>> 1;
		end
	end

	// Sequencer
	always_comb begin
		state_d       = state_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		mid_d         = mid_q;
		res_outcome_d = res_outcome_q;
		res_slot_d    = res_slot_q;
		rd_addr       = '0;
		case (state_q)
			ST_IDLE: begin
				// entry 0 is read speculatively every idle cycle
				rd_addr = '0;
				if (req_fire) begin
					lo_d = '0;
					hi_d = eff_count - sdts_pkg::idx_t'(1);
					if (req.command == sdts_pkg::CMD_LOAD) begin
						res_outcome_d = sdts_pkg::OUT_LOAD;
						res_slot_d    = '0;
						state_d       = ST_OUT;
					end else begin
						state_d = ST_LO;
					end
				end
			end
			ST_LO: begin
				rd_addr = sdts_pkg::addr_t'(hi_q);
				if (query_q < rd_data_q) begin
					res_outcome_d = sdts_pkg::OUT_UNDER;
					res_slot_d    = '0;
					state_d       = ST_OUT;
				end else begin
					state_d = ST_HI;
				end
			end
			ST_HI: begin
				mid_d   = hi_q >>> 1;
				rd_addr = sdts_pkg::addr_t'(hi_q >>> 1);
				if (query_q > rd_data_q) begin
					res_outcome_d = sdts_pkg::OUT_OVER;
					res_slot_d    = '0;
					state_d       = ST_OUT;
				end else if (lo_q < hi_q) begin
					state_d = ST_CMP;
				end else begin
					// single-entry range: lo equals hi
					res_outcome_d = sdts_pkg::OUT_INDEX;
					res_slot_d    = sdts_pkg::SLOT_W'(hi_q);
					state_d       = ST_OUT;
				end
			end
			ST_CMP: begin
				rd_addr = sdts_pkg::addr_t'(step_mid);
				if (query_q == rd_data_q) begin
					// hit inside the loop, where lo < hi still holds
					res_outcome_d = sdts_pkg::OUT_INDEX;
					res_slot_d    = sdts_pkg::SLOT_W'(mid_q);
					state_d       = ST_OUT;
				end else begin
					lo_d  = step_lo;
					hi_d  = step_hi;
					mid_d = step_mid;
					if (!(step_lo < step_hi)) begin
						res_outcome_d = sdts_pkg::OUT_INDEX;
						res_slot_d    = (step_lo == step_hi) ? sdts_pkg::SLOT_W'(step_hi)
						                                     : sdts_pkg::SLOT_W'(step_mid);
						state_d       = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			entries_in_use_q <= sdts_pkg::CFG_W'(1);
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				entries_in_use_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		lo_q          <= lo_d;
		hi_q          <= hi_d;
		mid_q         <= mid_d;
		res_outcome_q <= res_outcome_d;
		res_slot_q    <= res_slot_d;
		if (req_fire) begin
			query_q <= sdts_pkg::day_t'(req.query_day);
		end
		if (out_load) begin
			out_outcome_q <= res_outcome_q;
			out_slot_q    <= res_slot_q;
		end
	end

	// Day table RAM: writes only while idle, while the read port reads entry 0
	always_ff @(posedge clk) begin
		if (mem_we) begin
			day_mem[sdts_pkg::addr_t'(req.entry_slot)] <= sdts_pkg::day_t'(req.entry_day);
		end
		rd_data_q <= day_mem[rd_addr];
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.outcome    = out_outcome_q;
	assign rsp.found_slot = out_slot_q;

endmodule
`default_nettype wire

### sv/sdts_checker.sv
// Checker: port-level assertions for the sorted day table search block, with its bind.
`default_nettype none
module sdts_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [sdts_pkg::OUTCOME_W-1:0]     outcome,
	input wire logic [sdts_pkg::SLOT_W-1:0]        found_slot
);

	// A held response keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(found_slot))
		else $error("response changed while stalled");

	// Only an index result carries a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != sdts_pkg::OUT_INDEX) |-> found_slot == '0)
		else $error("nonzero slot on a non-index outcome");

	// One transaction in flight: ready drops after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while engine busy");

	// No response once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("response valid during reset");

endmodule

bind sorted_date_table_search sdts_checker u_sdts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.outcome    (rsp.outcome),
	.found_slot (rsp.found_slot)
);
`default_nettype wire
